### rtl/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_MBC1  = 2'd1;
   localparam logic [1:0] KIND_MBC3  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [1:0] TARGET_NONE = 2'd0;
   localparam logic [1:0] TARGET_ROM  = 2'd1;
   localparam logic [1:0] TARGET_RAM  = 2'd2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [7:0] ROM_BANK_RESET = 8'h01;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [2:0] RAM_WINDOW     = 3'b101;

   localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
   localparam logic [1:0] REG_ROM_BANK   = 2'd1;
   localparam logic [1:0] REG_RAM_BANK   = 2'd2;
   localparam logic [1:0] REG_MODE       = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [15:0] address;
      logic [7:0]  data;
   } access_type;

   typedef struct packed {
      logic [7:0] rom_bank;
      logic [1:0] ram_bank;
      logic       banking_mode;
      logic       ram_enabled;
   } bank_state_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [21:0] rom_address;
      logic [14:0] ram_address;
      logic        ram_write;
      logic [7:0]  write_data;
   } result_type;

endpackage

### rtl/cbc_bank_regs.sv
// Banking registers, updated by register-window writes.
module cbc_bank_regs import cbc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           update,
   input  logic [1:0]     kind,
   input  access_type     access,
   output bank_state_type bank
);

   bank_state_type bank_ff;
   bank_state_type bank_in;
   logic           mbc1;
   logic           banked;
   logic           reg_write;
   logic [4:0]     low_bank;

   assign mbc1      = (kind == KIND_MBC1);
   assign banked    = (kind == KIND_MBC1) || (kind == KIND_MBC3);
   assign reg_write = update && banked && (access.opcode == OP_WRITE)
                      && !access.address[15];
   assign low_bank  = (access.data[4:0] == 5'd0) ? 5'd1 : access.data[4:0];

   always_comb begin
      bank_in = bank_ff;
      if (reg_write) begin
         case (access.address[14:13])
            REG_RAM_ENABLE: begin
               bank_in.ram_enabled = (access.data[3:0] == RAM_ENABLE_KEY);
            end
            REG_ROM_BANK: begin
               if (mbc1) begin
                  bank_in.rom_bank = {1'b0, bank_ff.rom_bank[6:5], low_bank};
               end else begin
                  bank_in.rom_bank = (access.data == 8'd0) ? ROM_BANK_RESET
                                                           : access.data;
               end
            end
            REG_RAM_BANK: begin
               if (!mbc1 || bank_ff.banking_mode) begin
                  bank_in.ram_bank = access.data[1:0];
               end else begin
                  bank_in.rom_bank = {1'b0, access.data[1:0], bank_ff.rom_bank[4:0]};
               end
            end
            REG_MODE: begin
               bank_in.banking_mode = access.data[0];
               if (mbc1) begin
                  if (!access.data[0]) begin
                     bank_in.ram_bank = 2'd0;
                  end else begin
                     bank_in.rom_bank = {3'd0, bank_ff.rom_bank[4:0]};
                  end
               end
            end
            default: begin
               bank_in = bank_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff.rom_bank     <= ROM_BANK_RESET;
         bank_ff.ram_bank     <= 2'd0;
         bank_ff.banking_mode <= 1'b0;
         bank_ff.ram_enabled  <= 1'b0;
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign bank = bank_ff;

endmodule

### rtl/cbc_translate.sv
// Address decode and translation of one bus access.
module cbc_translate import cbc_pkg::*; (
   input  logic [1:0]     kind,
   input  access_type     access,
   input  bank_state_type bank,
   output result_type     result
);

   logic        banked;
   logic        in_ram;
   logic [15:0] addr;

   assign addr   = access.address;
   assign banked = (kind == KIND_MBC1) || (kind == KIND_MBC3);
   assign in_ram = (addr[15:13] == RAM_WINDOW);

   always_comb begin
      result = '0;
      if (!banked) begin
         if ((access.opcode == OP_READ) && !addr[15]) begin
            result.target      = TARGET_ROM;
            result.rom_address = {6'd0, addr};
         end
      end else if (access.opcode == OP_WRITE) begin
         if (in_ram && bank.ram_enabled) begin
            result.target      = TARGET_RAM;
            result.ram_address = {bank.ram_bank, addr[12:0]};
            result.ram_write   = 1'b1;
            result.write_data  = access.data;
         end
      end else if (!addr[15]) begin
         result.target = TARGET_ROM;
         if (!addr[14]) begin
            result.rom_address = {6'd0, addr};
         end else begin
            result.rom_address = {bank.rom_bank, addr[13:0]};
         end
      end else if (in_ram && bank.ram_enabled) begin
         result.target      = TARGET_RAM;
         result.ram_address = {bank.ram_bank, addr[12:0]};
      end
   end

endmodule

### rtl/cartridge_bank_controller_core.sv
// Top level of the cartridge bank controller: input stage, result stage, control.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser opcode, tdata address+data
//  rsp     | out | rsp_tvalid/tready  | tuser target, tdata addresses+strobe+byte
//  csr     | in  | csr_we             | csr_wdata controller kind
//
// One beat per cycle sustained while rsp is not stalled; an access goes from
// req to rsp via the input register, then the result register. Bank registers
// update as an access leaves the input register. Synchronous active-high reset
// empties both stages and restores bank defaults. A stalled rsp holds its beat;
// req keeps accepting while the input register is free or drains.
module cartridge_bank_controller_core import cbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,  // [0] opcode
   input  logic [23:0] req_tdata,  // [15:0] address, [23:16] data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,  // [1:0] target
   output logic [47:0] rsp_tdata,  // [21:0] rom_address, [36:22] ram_address,
                                   // [37] ram_write, [45:38] write_data, rest 0
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata
);

   logic [1:0]     kind_ff;
   logic           s1_valid_ff;
   access_type     s1_access_ff;
   logic           out_valid_ff;
   result_type     out_result_ff;
   logic           out_ready;
   logic           s1_fire;
   logic           req_fire;
   bank_state_type bank;
   result_type     result_in;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_PLAIN;
      end else if (csr_we) begin
         kind_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_access_ff.opcode  <= req_tuser[0];
         s1_access_ff.address <= req_tdata[15:0];
         s1_access_ff.data    <= req_tdata[23:16];
      end
   end

   cbc_bank_regs u_bank_regs (
      .clock  (clock),
      .reset  (reset),
      .update (s1_fire),
      .kind   (kind_ff),
      .access (s1_access_ff),
      .bank   (bank)
   );

   cbc_translate u_translate (
      .kind   (kind_ff),
      .access (s1_access_ff),
      .bank   (bank),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.target;
   assign rsp_tdata  = {2'd0, out_result_ff.write_data, out_result_ff.ram_write,
                        out_result_ff.ram_address, out_result_ff.rom_address};

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat did not reach the input stage");

   a_strobe_ram_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != TARGET_RAM)) |-> !rsp_tdata[37])
      else $error("RAM write strobe without RAM target");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == TARGET_NONE)) |-> (rsp_tdata == 48'd0))
      else $error("unmapped access carries nonzero payload");

   a_rom_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == TARGET_ROM)) |-> (rsp_tdata[47:22] == 26'd0))
      else $error("ROM result carries RAM fields");

endmodule
